/* src/urxf_pkg.sv */
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared types and constants of the 8N1 UART receiver with receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package urxf_pkg;

  localparam int unsigned FifoDepthDefault = 64;

  localparam int unsigned CpbW      = 16;
  localparam int unsigned CntDownW  = 17;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AvailW    = 6;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgRxEnable     = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgClocksPerBit = 1'd1;

  localparam logic            RxEnableReset     = 1'b1;
  localparam logic [CpbW-1:0] ClocksPerBitReset = 16'd868;

  localparam logic [2:0] LastBit = 3'd7;

  typedef enum logic [2:0] {
    PhHunt = 3'b001,
    PhData = 3'b010,
    PhStop = 3'b100
  } phase_e;

endpackage

`default_nettype wire

/* src/urxf_ram.sv */
// ----------------------------------------------------------------------------
// urxf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urxf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/uart_receiver_with_fifo_top.sv */
// ----------------------------------------------------------------------------
// uart_receiver_with_fifo_top
// 8N1 UART receiver with a ring receive FIFO, one line sample per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one line-sampling tick carrying rx_line and
// read_request; each produces exactly one output transaction. A new input is
// taken every cycle while the result side keeps up. The tick is processed and
// the FIFO RAM read is issued at the accepting edge, where the result is
// registered in stage 1; it then moves into the output register once that
// register is free. A stalled result holds off the input only once stage 1
// is also occupied. The FIFO holds up to FIFO_DEPTH-1 bytes; a full FIFO
// drops the byte and sets overflow. Configuration registers: index 0
// rx_enable, index 1 clocks_per_bit.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_receiver_with_fifo_top #(
  parameter int unsigned FIFO_DEPTH = urxf_pkg::FifoDepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           rx_line_i,
  input  wire logic                           read_request_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [urxf_pkg::ByteW-1:0]          read_byte_o,
  output logic                                read_valid_o,
  output logic [urxf_pkg::AvailW-1:0]         bytes_available_o,
  output logic                                byte_received_o,
  output logic                                framing_error_o,
  output logic                                overflow_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [urxf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [urxf_pkg::CfgDataW-1:0]  cfg_data_i
);

  import urxf_pkg::*;

  localparam int unsigned IdxW = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic              pop;
    logic              got;
    logic              ferr;
    logic              ovf;
    logic [AvailW-1:0] avail;
  } res_t;

  // configuration
  logic            rx_en_q;
  logic [CpbW-1:0] cpb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_en_q <= RxEnableReset;
      cpb_q   <= ClocksPerBitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRxEnable:     rx_en_q <= cfg_data_i[0];
        CfgClocksPerBit: cpb_q   <= cfg_data_i[CpbW-1:0];
        default:         ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  res_t s1_q;
  logic out_valid_q;
  res_t out_q;
  logic [ByteW-1:0] out_byte_q;
  logic out_free, s1_move, accept;
  logic [ByteW-1:0] ram_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // receiver and FIFO pointer state
  phase_e              phase_q, phase_d;
  logic [2:0]          bit_q, bit_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic [CntDownW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]     widx_q, widx_d, ridx_q, ridx_d;
  logic [IdxW:0]       cnt_pop, cnt_new;
  logic                pop, push;
  res_t                res;

  function automatic logic [IdxW:0] fill(input logic [IdxW-1:0] w, input logic [IdxW-1:0] r);
    logic [IdxW:0] d;
    begin
      d = (IdxW+1)'(FIFO_DEPTH);
      if (w >= r) begin
        fill = {1'b0, w} - {1'b0, r};
      end else begin
        fill = {1'b0, w} + d - {1'b0, r};
      end
    end
  endfunction

  function automatic logic [IdxW-1:0] incr(input logic [IdxW-1:0] i);
    begin
      if (i == IdxW'(FIFO_DEPTH - 1)) begin
        incr = '0;
      end else begin
        incr = i + 1'b1;
      end
    end
  endfunction

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    widx_d  = widx_q;
    ridx_d  = ridx_q;
    push    = 1'b0;
    res     = '0;

    pop = read_request_i && (widx_q != ridx_q);
    if (pop) begin
      ridx_d = incr(ridx_q);
    end
    cnt_pop = fill(widx_q, ridx_d);
    res.pop = pop;

    if (!rx_en_q) begin
      phase_d = PhHunt;
    end else if (phase_q != PhData && phase_q != PhStop) begin
      phase_d = PhHunt;
      if (!rx_line_i) begin
        phase_d = PhData;
        cnt_d   = {1'b0, cpb_q[CpbW-1:1], 1'b0} + {2'b00, cpb_q[CpbW-1:1]};
        bit_d   = '0;
        shift_d = '0;
      end
    end else if (cnt_q > CntDownW'(1)) begin
      cnt_d = cnt_q - 1'b1;
    end else if (phase_q == PhData) begin
      shift_d[bit_q] = shift_q[bit_q] | rx_line_i;
      if (bit_q == LastBit) begin
        phase_d = PhStop;
        bit_d   = '0;
      end else begin
        bit_d = bit_q + 1'b1;
      end
      cnt_d = {1'b0, cpb_q};
    end else begin
      if (!rx_line_i) begin
        res.ferr = 1'b1;
      end else begin
        res.got = 1'b1;
        if (cnt_pop >= (IdxW+1)'(FIFO_DEPTH - 1)) begin
          res.ovf = 1'b1;
        end else begin
          push   = 1'b1;
          widx_d = incr(widx_q);
        end
      end
      phase_d = PhHunt;
      cnt_d   = '0;
    end

    cnt_new   = fill(widx_d, ridx_d);
    res.avail = AvailW'(cnt_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      bit_q   <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      widx_q  <= '0;
      ridx_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      widx_q  <= widx_d;
      ridx_q  <= ridx_d;
    end
  end

  // FIFO storage; read issued on accept so data lines up with stage 1
  urxf_ram #(
    .Width (ByteW),
    .Depth (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (accept && push),
    .waddr_i (widx_q),
    .wdata_i (shift_d),
    .re_i    (accept && pop),
    .raddr_i (ridx_q),
    .rdata_o (ram_rdata)
  );

  // stage 1 and output register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
    if (s1_move) begin
      out_q      <= s1_q;
      out_byte_q <= s1_q.pop ? ram_rdata : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_byte_o       = out_byte_q;
  assign read_valid_o      = out_q.pop;
  assign bytes_available_o = out_q.avail;
  assign byte_received_o   = out_q.got;
  assign framing_error_o   = out_q.ferr;
  assign overflow_o        = out_q.ovf;

endmodule

`default_nettype wire
